[sv/subsequence_occurrence_counter_macros.svh]
// Assertion macros for the subsequence occurrence counter checker.
// Expect clk and rst_n in scope at the point of use.
`ifndef SUBSEQUENCE_OCCURRENCE_COUNTER_MACROS_SVH
`define SUBSEQUENCE_OCCURRENCE_COUNTER_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define SOCC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled in reset.
`define SOCC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[sv/socc_pkg.sv]
// Shared types and constants for the subsequence occurrence counter.
// No dependencies.
package socc_pkg;

  localparam int unsigned MAX_PATTERN_DEF = 16;
  localparam int unsigned KEY_W           = 32;
  localparam int unsigned COUNT_W         = 32;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  // Operation codes
  localparam logic [1:0] OP_APPEND = 2'd0;
  localparam logic [1:0] OP_FEED   = 2'd1;
  localparam logic [1:0] OP_FINISH = 2'd2;

  typedef struct packed {
    logic [1:0]              op;
    logic signed [KEY_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic [COUNT_W-1:0] occurrences;
    logic               saturated;
    logic               pattern_overflow;
  } out_item_t;

  // Per-cell control from the sequencer
  typedef struct packed {
    logic active;  // cell holds a pattern element
    logic load;    // take a new pattern element
    logic feed;    // update count against a text element
    logic clear;   // drop the job
  } cell_ctrl_t;

endpackage

[sv/subsequence_occurrence_counter.sv]
// Top level: sequencer, chain of counting cells and result register.
// Depends on socc_pkg and socc_cell.
//
//  Channel | Ports                          | Carries
//  input   | in_valid, in_ready, in_data    | op, value
//  output  | out_valid, out_ready, out_data | occurrences, saturated, pattern_overflow
//
// For every feed item, each active cell whose key matches updates its prefix count in
// parallel, from its left neighbor's count of the previous cycle.
// A finish loads the result register and clears the chain in the same cycle.
// Input is held off only while a result waits in the output register.
// Reset clears the length, flags, counts and the output valid; keys stay unknown.
module subsequence_occurrence_counter
  import socc_pkg::*;
#(
  parameter int unsigned MAX_PATTERN = MAX_PATTERN_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  localparam int unsigned LEN_W = $clog2(MAX_PATTERN + 1);

  logic [LEN_W-1:0]   len_r, len_nxt;
  logic               sat_r, sat_nxt;
  logic               ovf_r, ovf_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_item_t          out_data_r;

  logic               in_xfer;
  logic               do_append, do_feed, do_finish;
  logic               full;

  cell_ctrl_t         ctrl     [MAX_PATTERN];
  logic [COUNT_W-1:0] counts   [MAX_PATTERN];
  logic [COUNT_W-1:0] below    [MAX_PATTERN];
  logic [COUNT_W-1:0] last_sel [MAX_PATTERN];
  logic [MAX_PATTERN-1:0] sat_hits;
  logic [COUNT_W-1:0] total;
  logic               any_sat;

  assign in_ready  = !out_valid_r || out_ready;
  assign in_xfer   = in_valid && in_ready;
  assign do_append = in_xfer && (in_data.op == OP_APPEND);
  assign do_feed   = in_xfer && (in_data.op == OP_FEED);
  assign do_finish = in_xfer && (in_data.op == OP_FINISH);
  assign full      = (len_r == LEN_W'(MAX_PATTERN));

  for (genvar j = 0; j < MAX_PATTERN; j++) begin : g_cell
    always_comb begin
      ctrl[j].active = (LEN_W'(j) < len_r);
      ctrl[j].load   = do_append && (len_r == LEN_W'(j));
      ctrl[j].feed   = do_feed;
      ctrl[j].clear  = do_finish;
    end

    if (j == 0) begin : g_head
      assign below[j] = COUNT_W'(1);
    end else begin : g_link
      assign below[j] = counts[j-1];
    end

    // Mask every count but the one of the full pattern
    assign last_sel[j] = (len_r == LEN_W'(j + 1)) ? counts[j] : '0;

    socc_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctrl    (ctrl[j]),
      .key_in  (in_data.value),
      .below   (below[j]),
      .count   (counts[j]),
      .sat_hit (sat_hits[j])
    );
  end

  assign any_sat = |sat_hits;

  always_comb begin
    total = (len_r == '0) ? COUNT_W'(1) : '0;
    for (int j = 0; j < MAX_PATTERN; j++) begin
      total = total | last_sel[j];
    end
  end

  always_comb begin
    len_nxt       = len_r;
    sat_nxt       = sat_r;
    ovf_nxt       = ovf_r;
    out_valid_nxt = out_valid_r && !out_ready;
    if (do_append) begin
      if (full) begin
        ovf_nxt = 1'b1;
      end else begin
        len_nxt = len_r + LEN_W'(1);
      end
    end
    if (do_feed && any_sat) begin
      sat_nxt = 1'b1;
    end
    if (do_finish) begin
      len_nxt       = '0;
      sat_nxt       = 1'b0;
      ovf_nxt       = 1'b0;
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r       <= '0;
      sat_r       <= 1'b0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      len_r       <= len_nxt;
      sat_r       <= sat_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Hold the result until transfer
  always_ff @(posedge clk) begin
    if (do_finish) begin
      out_data_r.occurrences      <= total;
      out_data_r.saturated        <= sat_r;
      out_data_r.pattern_overflow <= ovf_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[sv/socc_cell.sv]
// One cell of the counting chain: a pattern key and its prefix count.
// Depends on socc_pkg.
module socc_cell
  import socc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  cell_ctrl_t         ctrl,
  input  logic [KEY_W-1:0]   key_in,
  input  logic [COUNT_W-1:0] below,      // count of the shorter prefix
  output logic [COUNT_W-1:0] count,
  output logic               sat_hit
);

  logic [KEY_W-1:0]   key_r;
  logic [COUNT_W-1:0] count_r, count_nxt;
  logic [COUNT_W:0]   sum;
  logic               hit;

  assign sum = {1'b0, count_r} + {1'b0, below};
  assign hit = ctrl.feed && ctrl.active && (key_r == key_in);

  always_comb begin
    count_nxt = count_r;
    sat_hit   = 1'b0;
    if (ctrl.clear || ctrl.load) begin
      count_nxt = '0;
    end else if (hit) begin
      if (sum >= {1'b0, COUNT_MAX}) begin
        count_nxt = COUNT_MAX;
        sat_hit   = 1'b1;
      end else begin
        count_nxt = sum[COUNT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  // Key store has no reset; read only once loaded
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      key_r <= key_in;
    end
  end

  assign count = count_r;

endmodule

[sv/socc_checker.sv]
// Port-level checks for the subsequence occurrence counter, bound to the top.
// Depends on socc_pkg and subsequence_occurrence_counter_macros.svh.
`include "subsequence_occurrence_counter_macros.svh"

module socc_checker
  import socc_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input in_item_t  in_data,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  `SOCC_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "result dropped or changed while stalled")
  `SOCC_ASSERT_NXT(a_finish_result, in_valid && in_ready && (in_data.op == OP_FINISH), out_valid, "finish gave no result")
  `SOCC_ASSERT_NXT(a_no_spurious, in_valid && in_ready && (in_data.op != OP_FINISH) && !out_valid, !out_valid, "result without finish")
  `SOCC_ASSERT_IMP(a_stall_input, out_valid && !out_ready, !in_ready, "input taken while result waits")

endmodule

bind subsequence_occurrence_counter socc_checker u_socc_checker (.*);
